[hdl/fqvd_pkg.sv]
`timescale 1ns / 1ps
// types and constants shared by the queue with delete by value
// no dependencies

package fqvd_pkg;

  // item field widths
  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // defaults for the top level parameters
  localparam int DEF_DEPTH      = 16;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_QUERY  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] item_value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] taken_value;
    logic               did_remove;
    logic [VALUE_W-1:0] head_value;
    logic [VALUE_W-1:0] tail_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } rsp_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic remove;
    logic clear;
  } cell_ctrl_t;

endpackage

[hdl/fifo_queue_with_value_delete.sv]
`timescale 1ns / 1ps
// top level of the queue with delete by value: row of cells and result register
// depends on fqvd_pkg and fqvd_cell
//
//   channel  direction  payload     handshake
//   req      in         req_item_t  req_valid / req_stall
//   rsp      out        rsp_item_t  rsp_valid / rsp_stall
//
// in the cell row every cell compares, shifts or
// loads in the same edge, so push, pop, remove and clear all finish at once.
// an item's result is formed from the updated row when it leaves the pending
// register, then sits in the output register; one item a cycle is sustained while
// rsp is not stalled. reset clears occupancy, the count and both handshake flags;
// entries hold no meaning until written. req is stalled only while a result
// waits behind a stalled output register.

module fifo_queue_with_value_delete import fqvd_pkg::*; #(
  parameter int DEPTH      = DEF_DEPTH,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  load_rsp;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] key;

  logic [DATA_WIDTH-1:0] cell_val   [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_hit;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  is_full;
  logic                  is_none;

  logic                  pend;
  logic [1:0]            pend_status;
  logic [VALUE_W-1:0]    pend_taken;
  logic                  pend_removed;
  logic [1:0]            status_next;
  logic [VALUE_W-1:0]    taken_next;
  logic                  removed_next;

  logic [DATA_WIDTH-1:0] tail_sel;
  logic [63:0]           head_wide;
  logic [63:0]           tail_wide;
  logic [63:0]           taken_wide;

  // handshake
  assign load_rsp  = pend && (!rsp_valid || !rsp_stall);
  assign req_stall = pend && !load_rsp;
  assign accept    = req_valid && !req_stall;

  assign key     = DATA_WIDTH'(64'(req.item_value));
  assign is_full = (count == CNT_W'(DEPTH));
  assign is_none = (count == '0);

  // decode the command for the row
  always_comb begin
    ctrl = '0;
    if (accept) begin
      case (req.mode)
        MODE_PUSH:   ctrl.push   = 1'b1;
        MODE_POP:    ctrl.pop    = 1'b1;
        MODE_REMOVE: ctrl.remove = 1'b1;
        MODE_CLEAR:  ctrl.clear  = 1'b1;
        default:     ctrl        = '0;
      endcase
    end
  end

  // row of cells, head in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_valid;
    logic                  hit_in;
    logic [DATA_WIDTH-1:0] next_val;
    logic                  next_valid;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
      assign hit_in     = 1'b0;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
      assign hit_in     = cell_hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val   = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_val   = cell_val[i+1];
      assign next_valid = cell_valid[i+1];
    end

    fqvd_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .key       (key),
      .prev_valid(prev_valid),
      .hit_in    (hit_in),
      .next_val  (next_val),
      .next_valid(next_valid),
      .val       (cell_val[i]),
      .valid     (cell_valid[i]),
      .hit_out   (cell_hit[i])
    );
  end

  // status, taken value and count for the accepted item
  assign taken_wide = 64'(cell_val[0]);

  always_comb begin
    status_next  = ST_OK;
    taken_next   = '0;
    removed_next = 1'b0;
    count_next   = count;
    case (req.mode)
      MODE_PUSH: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      MODE_POP: begin
        if (is_none) begin
          status_next = ST_EMPTY;
        end else begin
          taken_next   = taken_wide[VALUE_W-1:0];
          removed_next = 1'b1;
          count_next   = count - CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (is_none) begin
          status_next = ST_EMPTY;
        end else if (cell_hit[DEPTH-1]) begin
          removed_next = 1'b1;
          count_next   = count - CNT_W'(1);
        end
      end
      MODE_CLEAR: begin
        removed_next = !is_none;
        count_next   = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // pending result, waiting for the row to settle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (load_rsp) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status  <= status_next;
      pend_taken   <= taken_next;
      pend_removed <= removed_next;
    end
  end

  // tail: the last occupied cell
  always_comb begin
    tail_sel = '0;
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (cell_valid[i] && !cell_valid[i+1]) begin
        tail_sel = tail_sel | cell_val[i];
      end
    end
    if (cell_valid[DEPTH-1]) begin
      tail_sel = tail_sel | cell_val[DEPTH-1];
    end
  end

  assign head_wide = cell_valid[0] ? 64'(cell_val[0]) : 64'd0;
  assign tail_wide = 64'(tail_sel);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status      <= pend_status;
      rsp.taken_value <= pend_taken;
      rsp.did_remove  <= pend_removed;
      rsp.head_value  <= head_wide[VALUE_W-1:0];
      rsp.tail_value  <= tail_wide[VALUE_W-1:0];
      rsp.entry_count <= COUNT_W'(count);
      rsp.is_empty    <= !cell_valid[0];
    end
  end

endmodule

[hdl/fqvd_cell.sv]
`timescale 1ns / 1ps
// one storage cell of the queue row: holds one entry and its occupancy
// depends on fqvd_pkg

module fqvd_cell import fqvd_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic                  prev_valid,
  input  logic                  hit_in,
  input  logic [DATA_WIDTH-1:0] next_val,
  input  logic                  next_valid,
  output logic [DATA_WIDTH-1:0] val,
  output logic                  valid,
  output logic                  hit_out
);

  logic match;
  logic shift;
  logic load;

  // first-match chain: set from the first matching cell onwards
  assign match   = valid && (val == key);
  assign hit_out = hit_in || match;

  // take the neighbour's entry on pop, or at and behind a removed entry
  assign shift = ctrl.pop || (ctrl.remove && hit_out);

  // first free cell takes a pushed value
  assign load = ctrl.push && !valid && prev_valid;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= next_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  // entry value
  always_ff @(posedge clk) begin
    if (shift) begin
      val <= next_val;
    end else if (load) begin
      val <= key;
    end
  end

endmodule
